@@ rtl/core/dsd_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the 2x2 hole-aware depth downsampler.
// No dependencies; imported by every module of the block.
package dsd_pkg;

	localparam int MAX_WIDTH   = 2048;
	localparam int MAX_HEIGHT  = 2048;
	localparam int CFG_W       = 12;
	localparam int SAMPLE_W    = 16;
	localparam int AVG_W       = 15;
	localparam int COL_W       = $clog2(MAX_WIDTH);
	localparam int ROW_W       = $clog2(MAX_HEIGHT);
	localparam int STORE_DEPTH = MAX_WIDTH / 2;
	localparam int STORE_AW    = $clog2(STORE_DEPTH);
	localparam int PSUM_W      = 17;
	localparam int PCNT_W      = 2;
	localparam int ENTRY_W     = PSUM_W + PCNT_W;
	localparam int CNT_W       = 3;
	localparam int CFG_IDX_W   = 2;

	// ceil(2^17 / 3): exact floor division by three for sums below 2^17
	localparam int RECIP_SHIFT = 17;
	localparam logic [15:0] RECIP3 = 16'd43691;
	localparam int PROD_W      = PSUM_W + 16;

	localparam int OPQ_DEPTH   = 4;
	localparam int OPQ_AW      = $clog2(OPQ_DEPTH);
	localparam int RESQ_DEPTH  = 4;
	localparam int RESQ_AW     = $clog2(RESQ_DEPTH);

	localparam logic [CFG_W-1:0] SRC_WIDTH_RST  = 12'd640;
	localparam logic [CFG_W-1:0] SRC_HEIGHT_RST = 12'd480;

	localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;

	// One column pair on its way from the front to the back.
	typedef struct packed {
		logic                merge;  // odd row: combine with stored pair and emit
		logic [STORE_AW-1:0] idx;
		logic [PSUM_W-1:0]   psum;
		logic [PCNT_W-1:0]   pcnt;
		logic                last_row;
		logic                last_frame;
	} dsd_op_t;

	typedef struct packed {
		logic [AVG_W-1:0] avg;
		logic             hole;
		logic             last_row;
		logic             last_frame;
	} dsd_res_t;

endpackage

@@ rtl/core/depth_downsample_2x2_holes.sv @@
`timescale 1ns / 1ps
// Top level of the 2x2 hole-aware depth downsampler.
// Depends on dsd_pkg, dsd_front, dsd_opq and dsd_back.
//
// Accepts one depth sample per clock in raster order while full is low; the sustained
// rate is one sample per cycle, set by the front counters and the single-port line
// store, which sees at most one pair write or read per cycle. A result beat reaches
// the output queue after the bottom-right sample of its 2x2 block is accepted,
// through the queue hop, registered store read and divide register; merges wait
// while the result queue lacks room. Samples of zero or below are holes; each result
// is the truncated mean of the valid samples, or 0 with is_hole set. A trailing odd
// row or column produces nothing. The line store has no reset and needs no clearing
// pass: every entry is written on an even row before the odd row reads it. Change
// src_width/src_height only while the block is idle.
module depth_downsample_2x2_holes (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic signed [dsd_pkg::SAMPLE_W-1:0] depth_sample,
	output logic                                empty,
	input  logic                                pop,
	output logic [dsd_pkg::AVG_W-1:0]           avg_depth,
	output logic                                is_hole,
	output logic                                last_in_row,
	output logic                                last_in_frame,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [dsd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [dsd_pkg::CFG_W-1:0]           cfg_data
);
	import dsd_pkg::*;

	dsd_op_t front_op, head_op;
	logic    op_push, opq_full, opq_empty, op_pop;

	dsd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.depth_sample (depth_sample),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.op_push      (op_push),
		.op           (front_op),
		.opq_full     (opq_full)
	);

	dsd_opq u_opq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (op_push),
		.wr_op  (front_op),
		.full   (opq_full),
		.rd_en  (op_pop),
		.rd_op  (head_op),
		.empty  (opq_empty)
	);

	dsd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.op            (head_op),
		.op_empty      (opq_empty),
		.op_pop        (op_pop),
		.empty         (empty),
		.pop           (pop),
		.avg_depth     (avg_depth),
		.is_hole       (is_hole),
		.last_in_row   (last_in_row),
		.last_in_frame (last_in_frame)
	);

endmodule

@@ rtl/core/dsd_front.sv @@
`timescale 1ns / 1ps
// Front end: configuration registers, raster counters, left-sample hold and pair sums.
// Depends on dsd_pkg.
module dsd_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic signed [dsd_pkg::SAMPLE_W-1:0] depth_sample,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [dsd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dsd_pkg::CFG_W-1:0]     cfg_data,
	output logic                          op_push,
	output dsd_pkg::dsd_op_t              op,
	input  logic                          opq_full
);
	import dsd_pkg::*;

	localparam int WEXT_W = (CFG_W > COL_W + 2) ? CFG_W : COL_W + 2;
	localparam int HEXT_W = (CFG_W > ROW_W + 2) ? CFG_W : ROW_W + 2;

	logic [CFG_W-1:0]    src_width_q, src_height_q;
	logic [SAMPLE_W-1:0] left_q;
	logic [COL_W-1:0]    col_q, col_cur;
	logic [ROW_W-1:0]    row_q, row_cur;
	logic [WEXT_W-1:0]   w_raw, w_eff, col_ext;
	logic [HEXT_W-1:0]   h_raw, h_eff, row_ext;
	logic                accept, col_wrap, row_wrap;
	logic [PSUM_W-1:0]   a_val, b_val;

	function automatic logic [PSUM_W-1:0] valid_part(input logic [SAMPLE_W-1:0] s);
		logic [PSUM_W-1:0] r;
		r = '0;
		if (!s[SAMPLE_W-1] && s != '0)
			r = PSUM_W'(s);
		return r;
	endfunction

	assign cfg_ready = 1'b1;
	assign full      = opq_full;
	assign accept    = push && !full;

	always_comb begin
		w_raw = WEXT_W'(src_width_q);
		h_raw = HEXT_W'(src_height_q);
		if (w_raw < WEXT_W'(2))
			w_eff = WEXT_W'(2);
		else if (w_raw > WEXT_W'(MAX_WIDTH))
			w_eff = WEXT_W'(MAX_WIDTH);
		else
			w_eff = w_raw;
		if (h_raw < HEXT_W'(2))
			h_eff = HEXT_W'(2);
		else if (h_raw > HEXT_W'(MAX_HEIGHT))
			h_eff = HEXT_W'(MAX_HEIGHT);
		else
			h_eff = h_raw;

		// a size shrunk mid-frame pins the counters to the last column/row
		col_cur = (WEXT_W'(col_q) >= w_eff) ? COL_W'(w_eff - WEXT_W'(1)) : col_q;
		row_cur = (HEXT_W'(row_q) >= h_eff) ? ROW_W'(h_eff - HEXT_W'(1)) : row_q;
		col_ext = WEXT_W'(col_cur);
		row_ext = HEXT_W'(row_cur);
		col_wrap = (col_ext + WEXT_W'(1)) >= w_eff;
		row_wrap = (row_ext + HEXT_W'(1)) >= h_eff;

		a_val = valid_part(left_q);
		b_val = valid_part(depth_sample);

		op.merge      = row_cur[0];
		op.idx        = STORE_AW'(col_cur >> 1);
		op.psum       = a_val + b_val;
		op.pcnt       = PCNT_W'({1'b0, a_val != '0} + {1'b0, b_val != '0});
		op.last_row   = (col_ext + WEXT_W'(3)) > w_eff;
		op.last_frame = op.last_row && ((row_ext + HEXT_W'(3)) > h_eff);
		op_push       = accept && col_cur[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= SRC_WIDTH_RST;
			src_height_q <= SRC_HEIGHT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SRC_WIDTH:  src_width_q  <= cfg_data;
				REG_SRC_HEIGHT: src_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
			col_q  <= '0;
			row_q  <= '0;
		end else if (accept) begin
			if (!col_cur[0])
				left_q <= depth_sample;
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : row_cur + ROW_W'(1);
			end else begin
				col_q <= col_cur + COL_W'(1);
				row_q <= row_cur;
			end
		end
	end

endmodule

@@ rtl/core/dsd_opq.sv @@
`timescale 1ns / 1ps
// Short queue of pair operations between the front and the back.
// Depends on dsd_pkg.
module dsd_opq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  dsd_pkg::dsd_op_t wr_op,
	output logic             full,
	input  logic             rd_en,
	output dsd_pkg::dsd_op_t rd_op,
	output logic             empty
);
	import dsd_pkg::*;

	dsd_op_t             slot_q [OPQ_DEPTH];
	logic [OPQ_AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [OPQ_AW:0]     cnt_q;
	logic                do_wr, do_rd;

	assign full  = cnt_q == (OPQ_AW+1)'(OPQ_DEPTH);
	assign empty = cnt_q == '0;
	assign rd_op = slot_q[rd_ptr_q];
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;

	always_ff @(posedge clk) begin
		if (do_wr)
			slot_q[wr_ptr_q] <= wr_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= wr_ptr_q + OPQ_AW'(1);
			if (do_rd)
				rd_ptr_q <= rd_ptr_q + OPQ_AW'(1);
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + (OPQ_AW+1)'(1);
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - (OPQ_AW+1)'(1);
		end
	end

endmodule

@@ rtl/core/dsd_back.sv @@
`timescale 1ns / 1ps
// Back end: pair line store, merge and divide pipeline, result queue.
// Depends on dsd_pkg.
module dsd_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  dsd_pkg::dsd_op_t             op,
	input  logic                         op_empty,
	output logic                         op_pop,
	output logic                         empty,
	input  logic                         pop,
	output logic [dsd_pkg::AVG_W-1:0]    avg_depth,
	output logic                         is_hole,
	output logic                         last_in_row,
	output logic                         last_in_frame
);
	import dsd_pkg::*;

	logic [ENTRY_W-1:0] store [STORE_DEPTH];
	logic [ENTRY_W-1:0] rd_data_q;

	logic                v_s1, v_s2;
	logic [PSUM_W-1:0]   psum_s1, sum_s2;
	logic [PCNT_W-1:0]   pcnt_s1;
	logic [CNT_W-1:0]    cnt_s2;
	logic [PROD_W-1:0]   prod_s2;
	logic                lr_s1, lf_s1, lr_s2, lf_s2;

	logic [PSUM_W-1:0]   sum_c;
	logic [CNT_W-1:0]    cnt_c;
	logic [PROD_W-1:0]   prod_c;
	logic                room, rd_go, wr_go;

	dsd_res_t            res_q [RESQ_DEPTH];
	dsd_res_t            res_c;
	logic [RESQ_AW-1:0]  res_wr_q, res_rd_q;
	logic [RESQ_AW:0]    res_cnt_q;
	logic                res_pop;

	// a merge is issued only when the result queue has space for every beat in flight
	assign room   = (res_cnt_q + (RESQ_AW+1)'(v_s1) + (RESQ_AW+1)'(v_s2))
	                < (RESQ_AW+1)'(RESQ_DEPTH);
	assign op_pop = !op_empty && (!op.merge || room);
	assign rd_go  = op_pop && op.merge;
	assign wr_go  = op_pop && !op.merge;

	always_ff @(posedge clk) begin
		if (wr_go)
			store[op.idx] <= {op.pcnt, op.psum};
		if (rd_go)
			rd_data_q <= store[op.idx];
	end

	always_comb begin
		sum_c  = psum_s1 + rd_data_q[PSUM_W-1:0];
		cnt_c  = CNT_W'(pcnt_s1) + CNT_W'(rd_data_q[ENTRY_W-1:PSUM_W]);
		prod_c = PROD_W'(sum_c) * PROD_W'(RECIP3);
	end

	always_ff @(posedge clk) begin
		if (rd_go) begin
			psum_s1 <= op.psum;
			pcnt_s1 <= op.pcnt;
			lr_s1   <= op.last_row;
			lf_s1   <= op.last_frame;
		end
		if (v_s1) begin
			sum_s2  <= sum_c;
			cnt_s2  <= cnt_c;
			prod_s2 <= prod_c;
			lr_s2   <= lr_s1;
			lf_s2   <= lf_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= rd_go;
			v_s2 <= v_s1;
		end
	end

	always_comb begin
		unique case (cnt_s2)
			3'd1:    res_c.avg = AVG_W'(sum_s2);
			3'd2:    res_c.avg = AVG_W'(sum_s2 >> 1);
			3'd3:    res_c.avg = AVG_W'(prod_s2 >> RECIP_SHIFT);
			3'd4:    res_c.avg = AVG_W'(sum_s2 >> 2);
			default: res_c.avg = '0;
		endcase
		res_c.hole       = cnt_s2 == '0;
		res_c.last_row   = lr_s2;
		res_c.last_frame = lf_s2;
	end

	assign empty         = res_cnt_q == '0;
	assign res_pop       = pop && !empty;
	assign avg_depth     = res_q[res_rd_q].avg;
	assign is_hole       = res_q[res_rd_q].hole;
	assign last_in_row   = res_q[res_rd_q].last_row;
	assign last_in_frame = res_q[res_rd_q].last_frame;

	always_ff @(posedge clk) begin
		if (v_s2)
			res_q[res_wr_q] <= res_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_wr_q  <= '0;
			res_rd_q  <= '0;
			res_cnt_q <= '0;
		end else begin
			if (v_s2)
				res_wr_q <= res_wr_q + RESQ_AW'(1);
			if (res_pop)
				res_rd_q <= res_rd_q + RESQ_AW'(1);
			if (v_s2 && !res_pop)
				res_cnt_q <= res_cnt_q + (RESQ_AW+1)'(1);
			else if (res_pop && !v_s2)
				res_cnt_q <= res_cnt_q - (RESQ_AW+1)'(1);
		end
	end

	a_no_res_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> res_cnt_q != (RESQ_AW+1)'(RESQ_DEPTH))
		else $error("result beat arrived with result queue full");

	a_merge_flows: assert property (@(posedge clk) disable iff (!arst_n)
		rd_go |=> v_s1 ##1 v_s2)
		else $error("merge beat lost in back pipeline");

	a_one_per_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({rd_go, wr_go}) <= 1)
		else $error("store read and write issued together");

endmodule
